// ----- src/ccrgb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccrgb_pkg
// Shared types and constants of the center crop RGB565 to RGB888 block.
// ----------------------------------------------------------------------------
package ccrgb_pkg;

    localparam int unsigned CFG_W     = 11;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_COLS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_ROWS  = 2'd3;

    localparam logic [CFG_W-1:0] FRAME_COLS_RST = 11'd176;
    localparam logic [CFG_W-1:0] FRAME_ROWS_RST = 11'd144;
    localparam logic [CFG_W-1:0] CROP_COLS_RST  = 11'd96;
    localparam logic [CFG_W-1:0] CROP_ROWS_RST  = 11'd96;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [15:0] pix;
        logic        last;
    } t_entry;

endpackage
`default_nettype wire

// ----- src/ccrgb_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccrgb_in_if
// Request channel carrying raw camera frame bytes.
// ----------------------------------------------------------------------------
interface ccrgb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       frame_start;

    modport source (output valid, output pixel_byte, output frame_start, input ready);
    modport sink (input valid, input pixel_byte, input frame_start, output ready);
endinterface
`default_nettype wire

// ----- src/ccrgb_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccrgb_out_if
// Request channel carrying expanded RGB888 pixels of the cropped window.
// ----------------------------------------------------------------------------
interface ccrgb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;

    modport source (
        output valid, output red, output green, output blue, output last_pixel,
        input ready
    );
    modport sink (
        input valid, input red, input green, input blue, input last_pixel,
        output ready
    );
endinterface
`default_nettype wire

// ----- src/ccrgb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccrgb_front
// Configuration registers, window geometry, byte and pixel counters, and
// the classification of each pixel against the centered crop window.
// ----------------------------------------------------------------------------
module ccrgb_front #(
    parameter int unsigned MAX_DIM = 1024
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [ccrgb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [ccrgb_pkg::CFG_W-1:0]     i_cfg_data,
    ccrgb_in_if.sink                      i_pix,
    output logic                          o_push,
    output ccrgb_pkg::t_entry             o_entry,
    input  wire                           i_full
);
    import ccrgb_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_DIM);
    localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
    localparam int unsigned WW    = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam logic [WW-1:0] MAX_W = WW'(MAX_DIM);

    logic [CFG_W-1:0] r_cfg_fc, r_cfg_fr, r_cfg_cc, r_cfg_cr;
    logic [CFG_W-1:0] n_cfg_fc, n_cfg_fr, n_cfg_cc, n_cfg_cr;

    logic [WW-1:0] w_fc_e, w_fr_e, w_cc_e, w_cr_e;
    logic [WW-1:0] w_fc, w_fr, w_cc, w_cr;
    logic [WW-1:0] w_fc_m1, w_fr_m1, w_left, w_top, w_right, w_bottom;

    logic [CNT_W-1:0] r_fc_m1, r_fr_m1, r_left, r_right, r_top, r_bottom;

    logic [CNT_W-1:0] r_col, r_row;
    logic             r_phase;
    logic [7:0]       r_held;
    logic [CNT_W-1:0] n_col, n_row;
    logic             n_phase;

    logic             w_acc;
    logic             w_phase;
    logic [CNT_W-1:0] w_col_raw, w_row_raw, w_col, w_row;
    logic             w_keep;

    always_comb begin
        if (!i_rst_n) begin
            n_cfg_fc = FRAME_COLS_RST;
            n_cfg_fr = FRAME_ROWS_RST;
            n_cfg_cc = CROP_COLS_RST;
            n_cfg_cr = CROP_ROWS_RST;
        end else begin
            n_cfg_fc = r_cfg_fc;
            n_cfg_fr = r_cfg_fr;
            n_cfg_cc = r_cfg_cc;
            n_cfg_cr = r_cfg_cr;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_COLS: n_cfg_fc = i_cfg_data;
                    REG_FRAME_ROWS: n_cfg_fr = i_cfg_data;
                    REG_CROP_COLS:  n_cfg_cc = i_cfg_data;
                    REG_CROP_ROWS:  n_cfg_cr = i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // The geometry registers follow the next configuration value, so a new
    // size is in effect from the cycle after its write.
    always_comb begin
        w_fc_e   = WW'(n_cfg_fc);
        w_fr_e   = WW'(n_cfg_fr);
        w_cc_e   = WW'(n_cfg_cc);
        w_cr_e   = WW'(n_cfg_cr);
        w_fc     = (w_fc_e == '0) ? WW'(1) : ((w_fc_e > MAX_W) ? MAX_W : w_fc_e);
        w_fr     = (w_fr_e == '0) ? WW'(1) : ((w_fr_e > MAX_W) ? MAX_W : w_fr_e);
        w_cc     = (w_cc_e == '0) ? WW'(1) : ((w_cc_e > w_fc) ? w_fc : w_cc_e);
        w_cr     = (w_cr_e == '0) ? WW'(1) : ((w_cr_e > w_fr) ? w_fr : w_cr_e);
        w_fc_m1  = w_fc - WW'(1);
        w_fr_m1  = w_fr - WW'(1);
        w_left   = (w_fc - w_cc) >> 1;
        w_top    = (w_fr - w_cr) >> 1;
        w_right  = w_left + w_cc - WW'(1);
        w_bottom = w_top + w_cr - WW'(1);
    end

    always_ff @(posedge i_clk) begin
        r_cfg_fc <= n_cfg_fc;
        r_cfg_fr <= n_cfg_fr;
        r_cfg_cc <= n_cfg_cc;
        r_cfg_cr <= n_cfg_cr;
        r_fc_m1  <= w_fc_m1[CNT_W-1:0];
        r_fr_m1  <= w_fr_m1[CNT_W-1:0];
        r_left   <= w_left[CNT_W-1:0];
        r_top    <= w_top[CNT_W-1:0];
        r_right  <= w_right[CNT_W-1:0];
        r_bottom <= w_bottom[CNT_W-1:0];
    end

    assign i_pix.ready = !i_full;
    assign w_acc       = i_pix.valid && !i_full;

    always_comb begin
        w_phase   = i_pix.frame_start ? 1'b0 : r_phase;
        w_col_raw = i_pix.frame_start ? '0 : r_col;
        w_row_raw = i_pix.frame_start ? '0 : r_row;
        w_col     = (w_col_raw > r_fc_m1) ? '0 : w_col_raw;
        w_row     = (w_row_raw > r_fr_m1) ? '0 : w_row_raw;
        w_keep    = (w_col >= r_left) && (w_col <= r_right) &&
                    (w_row >= r_top) && (w_row <= r_bottom);
        n_phase   = !w_phase;
        n_col     = w_col_raw;
        n_row     = w_row_raw;
        if (w_phase) begin
            if (w_col == r_fc_m1) begin
                n_col = '0;
                n_row = (w_row == r_fr_m1) ? '0 : w_row + CNT_W'(1);
            end else begin
                n_col = w_col + CNT_W'(1);
                n_row = w_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= 1'b0;
        end else if (w_acc) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !w_phase) begin
            r_held <= i_pix.pixel_byte;
        end
    end

    assign o_push       = w_acc && w_phase && w_keep;
    assign o_entry.pix  = {r_held, i_pix.pixel_byte};
    assign o_entry.last = (w_col == r_right) && (w_row == r_bottom);

endmodule
`default_nettype wire

// ----- src/ccrgb_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccrgb_fifo
// Short queue of kept RGB565 pixels between the front and back parts.
// ----------------------------------------------------------------------------
module ccrgb_fifo (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  ccrgb_pkg::t_entry i_entry,
    output logic              o_full,
    output logic              o_valid,
    output ccrgb_pkg::t_entry o_entry,
    input  wire               i_pop
);
    import ccrgb_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/ccrgb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccrgb_back
// Expands queued RGB565 pixels to RGB888 into the output register.
// ----------------------------------------------------------------------------
module ccrgb_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  ccrgb_pkg::t_entry i_entry,
    output logic              o_pop,
    ccrgb_out_if.source       o_rgb
);
    import ccrgb_pkg::*;

    logic       r_valid;
    logic [7:0] r_red, r_green, r_blue;
    logic       r_last;
    logic [4:0] w_r5, w_b5;
    logic [5:0] w_g6;

    assign o_pop = i_valid && (!r_valid || o_rgb.ready);
    assign w_r5  = i_entry.pix[15:11];
    assign w_g6  = i_entry.pix[10:5];
    assign w_b5  = i_entry.pix[4:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_rgb.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_red   <= {w_r5, w_r5[4:2]};
            r_green <= {w_g6, w_g6[5:4]};
            r_blue  <= {w_b5, w_b5[4:2]};
            r_last  <= i_entry.last;
        end
    end

    assign o_rgb.valid      = r_valid;
    assign o_rgb.red        = r_red;
    assign o_rgb.green      = r_green;
    assign o_rgb.blue       = r_blue;
    assign o_rgb.last_pixel = r_last;

endmodule
`default_nettype wire

// ----- src/center_crop_rgb565_to_rgb888.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// center_crop_rgb565_to_rgb888
// Keeps the centered window of a raster RGB565 byte stream and expands each
// kept pixel to RGB888.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle while the queue is not full.
// A kept pixel is queued as its low byte is taken, then moves to the output register.
// The two-entry queue and the output register let input and output stall apart.
// Synchronous reset clears the counters, the queue and the output valid, and
// loads the register reset sizes 176 x 144 frame and 96 x 96 window.
module center_crop_rgb565_to_rgb888 #(
    parameter int unsigned MAX_DIM = 1024
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [ccrgb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [ccrgb_pkg::CFG_W-1:0]     i_cfg_data,
    ccrgb_in_if.sink                       i_pix,
    ccrgb_out_if.source                    o_rgb
);
    import ccrgb_pkg::*;

    logic   w_push, w_full, w_qvalid, w_pop;
    t_entry w_push_entry, w_q_entry;

    ccrgb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .o_push     (w_push),
        .o_entry    (w_push_entry),
        .i_full     (w_full)
    );

    ccrgb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    ccrgb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_entry (w_q_entry),
        .o_pop   (w_pop),
        .o_rgb   (o_rgb)
    );

endmodule
`default_nettype wire

// ----- sim/tb_center_crop_rgb565_to_rgb888.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_center_crop_rgb565_to_rgb888
// Self-checking bench for the center crop and RGB565 to RGB888 expansion.
// ----------------------------------------------------------------------------
// Frame bytes go in through the pixel channel while a model of the crop
// window tracks column, row and byte phase. It queues the expanded pixel
// expected for every kept low byte. Each pixel that leaves the block is
// compared field by field with the oldest queued one. Window sizes are
// changed only while no pixel is outstanding. Both channels pause in random
// bursts except during the final stretch of random frames.
module tb_center_crop_rgb565_to_rgb888;
    import ccrgb_pkg::*;

    localparam int unsigned MAX_DIM       = 1024;
    localparam int unsigned QUIET_LIMIT   = 400;
    localparam int unsigned BYTE_TARGET   = 650;
    localparam int unsigned CALM_FROM     = 560;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } t_rgb888;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    ccrgb_in_if  pix_if ();
    ccrgb_out_if rgb_if ();

    center_crop_rgb565_to_rgb888 #(
        .MAX_DIM(MAX_DIM)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_pix     (pix_if.sink),
        .o_rgb     (rgb_if.source)
    );

    logic [CFG_W-1:0] size_reg [4];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    bit               low_phase;
    logic [7:0]       high_byte;

    t_rgb888     pending_rgb [$];
    int unsigned fail_count;
    int unsigned bytes_sent;
    int unsigned quiet_cycles;
    int unsigned send_pause_pct;
    int unsigned take_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned fit_dim(input int unsigned v, input int unsigned hi);
        if (v == 0) begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic void reset_window_model();
        size_reg[REG_FRAME_COLS] = FRAME_COLS_RST;
        size_reg[REG_FRAME_ROWS] = FRAME_ROWS_RST;
        size_reg[REG_CROP_COLS]  = CROP_COLS_RST;
        size_reg[REG_CROP_ROWS]  = CROP_ROWS_RST;
        col_cnt   = 0;
        row_cnt   = 0;
        low_phase = 1'b0;
        high_byte = 8'h00;
    endfunction

    // Advances the window model by one accepted byte and queues the kept pixel.
    function automatic void crop_and_expand(input logic [7:0] b, input logic fs);
        int unsigned fc, fr, cc, cr, left, top, right, bottom, c, r;
        logic [15:0] pix;
        t_rgb888     px;
        fc     = fit_dim(size_reg[REG_FRAME_COLS], MAX_DIM);
        fr     = fit_dim(size_reg[REG_FRAME_ROWS], MAX_DIM);
        cc     = fit_dim(size_reg[REG_CROP_COLS], fc);
        cr     = fit_dim(size_reg[REG_CROP_ROWS], fr);
        left   = (fc - cc) / 2;
        top    = (fr - cr) / 2;
        right  = left + cc - 1;
        bottom = top + cr - 1;
        if (fs) begin
            col_cnt   = 0;
            row_cnt   = 0;
            low_phase = 1'b0;
        end
        if (!low_phase) begin
            high_byte = b;
            low_phase = 1'b1;
            return;
        end
        low_phase = 1'b0;
        c = (col_cnt >= fc) ? 0 : col_cnt;
        r = (row_cnt >= fr) ? 0 : row_cnt;
        if (c >= left && c <= right && r >= top && r <= bottom) begin
            pix           = {high_byte, b};
            px.red        = {pix[15:11], pix[15:13]};
            px.green      = {pix[10:5], pix[10:9]};
            px.blue       = {pix[4:0], pix[4:2]};
            px.last_pixel = (c == right && r == bottom);
            pending_rgb.push_back(px);
        end
        c++;
        if (c >= fc) begin
            c = 0;
            r++;
            if (r >= fr) begin
                r = 0;
            end
        end
        col_cnt = c;
        row_cnt = r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%02h, got 0x%02h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : rgb_check
        t_rgb888 want;
        if (i_rst_n && rgb_if.valid && rgb_if.ready) begin
            if (pending_rgb.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, got %0h %0h %0h last %0b",
                         $time, rgb_if.red, rgb_if.green, rgb_if.blue, rgb_if.last_pixel);
                fail_count++;
            end else begin
                want = pending_rgb.pop_front();
                check_field("red", want.red, rgb_if.red);
                check_field("green", want.green, rgb_if.green);
                check_field("blue", want.blue, rgb_if.blue);
                check_field("last_pixel", {7'd0, want.last_pixel}, {7'd0, rgb_if.last_pixel});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (rgb_if.valid && rgb_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        rgb_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < take_stall_pct) begin
                rgb_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            rgb_if.ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fs);
        if ($urandom_range(0, 99) < send_pause_pct) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_byte  <= b;
        pix_if.frame_start <= fs;
        do @(posedge i_clk); while (!pix_if.ready);
        crop_and_expand(b, fs);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_pixel(input logic [15:0] px, input logic fs);
        send_byte(px[15:8], fs);
        send_byte(px[7:0], 1'b0);
    endtask

    task automatic drain_pixels();
        pix_if.valid <= 1'b0;
        while (pending_rgb.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        size_reg[idx] = val;
        @(negedge i_clk);
    endtask

    task automatic load_sizes(input logic [CFG_W-1:0] fc, input logic [CFG_W-1:0] fr,
                              input logic [CFG_W-1:0] cc, input logic [CFG_W-1:0] cr);
        drain_pixels();
        write_reg(REG_FRAME_COLS, fc);
        write_reg(REG_FRAME_ROWS, fr);
        write_reg(REG_CROP_COLS, cc);
        write_reg(REG_CROP_ROWS, cr);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] any_pixel();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pixels(input int unsigned count, input logic mark);
        for (int unsigned i = 0; i < count; i++) begin
            send_pixel(any_pixel(), mark && i == 0);
        end
    endtask

    // A 4 x 2 frame with a 2 x 2 window, then a wrap without a start mark
    // and a start mark that lands on a low byte.
    task automatic test_directed_pixels();
        send_pause_pct = 30;
        take_stall_pct = 30;
        load_sizes(11'd4, 11'd2, 11'd2, 11'd2);
        send_pixel(16'h1234, 1'b1);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h5A5A, 1'b0);
        send_pixel(16'hA5A5, 1'b0);
        send_pixel(16'hF800, 1'b0);
        send_pixel(16'h07E0, 1'b0);
        send_pixel(16'hFF00, 1'b0);
        send_pixel(16'h00FF, 1'b0);
        send_pixel(16'h001F, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h81, 1'b0);
    endtask

    task automatic test_size_clamping();
        send_pause_pct = 20;
        take_stall_pct = 40;
        load_sizes(11'd0, 11'd0, 11'd0, 11'd0);
        send_pixels(8, 1'b1);
        load_sizes(11'd2047, 11'd1, 11'd1023, 11'd2047);
        send_pixels(30, 1'b1);
        load_sizes(11'd5, 11'd3, 11'd7, 11'd9);
        send_pixels(15, 1'b1);
        load_sizes(11'd1024, 11'd2, 11'd1024, 11'd1024);
        send_pixels(20, 1'b1);
        load_sizes(11'd1, 11'd1024, 11'd1, 11'd1022);
        send_pixels(20, 1'b1);
    endtask

    task automatic test_midframe_resize();
        send_pause_pct = 10;
        take_stall_pct = 10;
        load_sizes(11'd2047, 11'd1, 11'd1023, 11'd2047);
        send_pixels(12, 1'b1);
        load_sizes(11'd6, 11'd1, 11'd2, 11'd2047);
        send_pixels(10, 1'b0);
    endtask

    task automatic test_random_frames();
        int unsigned fc, fr, cc, cr, frames, npix;
        logic        mark;
        while (bytes_sent < BYTE_TARGET) begin
            if (bytes_sent >= CALM_FROM) begin
                send_pause_pct = 0;
                take_stall_pct = 0;
            end else begin
                send_pause_pct = $urandom_range(0, 2) * 25;
                take_stall_pct = $urandom_range(0, 2) * 25;
            end
            fc = $urandom_range(0, 10);
            fr = $urandom_range(0, 6);
            cc = $urandom_range(0, 12);
            cr = $urandom_range(0, 8);
            load_sizes(fc[CFG_W-1:0], fr[CFG_W-1:0], cc[CFG_W-1:0], cr[CFG_W-1:0]);
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames && bytes_sent < BYTE_TARGET; f++) begin
                npix = fit_dim(fc, MAX_DIM) * fit_dim(fr, MAX_DIM);
                if ($urandom_range(0, 5) == 0) begin
                    npix = $urandom_range(1, npix);
                end
                mark = ($urandom_range(0, 9) != 0);
                for (int unsigned i = 0; i < npix && bytes_sent < BYTE_TARGET; i++) begin
                    if (bytes_sent >= CALM_FROM) begin
                        send_pause_pct = 0;
                        take_stall_pct = 0;
                    end
                    if ($urandom_range(0, 39) == 0) begin
                        send_byte(8'($urandom), 1'b0);
                        send_byte(8'($urandom), 1'b1);
                        send_byte(8'($urandom), 1'b0);
                    end else begin
                        send_pixel(any_pixel(), mark && i == 0);
                    end
                end
            end
        end
    endtask

    initial begin
        fail_count     = 0;
        bytes_sent     = 0;
        send_pause_pct = 0;
        take_stall_pct = 0;
        reset_window_model();
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= REG_FRAME_COLS;
        cfg_data           <= '0;
        pix_if.valid       <= 1'b0;
        pix_if.pixel_byte  <= 8'h00;
        pix_if.frame_start <= 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_pixels();
        test_size_clamping();
        test_midframe_resize();
        test_random_frames();

        drain_pixels();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending_rgb.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
